### design/present_pkg.sv
package present_pkg;

  // Block and key register widths.
  localparam int BLOCK_W    = 64;
  localparam int KEY_W      = 64;
  // Default number of round keys.
  localparam int ROUNDS_DEF = 32;
  // The round counter is masked to this many bits before it enters the key.
  localparam int RC_W       = 5;
  // Width of the configuration register index.
  localparam int CFG_IDX_W  = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = CFG_IDX_W'(1);

  // Operation codes.
  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  // Forward and inverse 4-bit S-boxes.
  localparam logic [3:0] SBOX [16] = '{
    4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
    4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
  };
  localparam logic [3:0] SBOX_INV [16] = '{
    4'h5, 4'hE, 4'hF, 4'h8, 4'hC, 4'h1, 4'h2, 4'hD,
    4'hB, 4'h4, 4'h6, 4'h3, 4'h0, 4'h7, 4'h9, 4'hA
  };

  // Apply the forward S-box to all sixteen nibbles.
  function automatic logic [BLOCK_W-1:0] sub_fwd(input logic [BLOCK_W-1:0] v);
    logic [BLOCK_W-1:0] r;
    r = '0;
    for (int n = 0; n < BLOCK_W / 4; n++) begin
      r[4*n +: 4] = SBOX[v[4*n +: 4]];
    end
    return r;
  endfunction

  // Apply the inverse S-box to all sixteen nibbles.
  function automatic logic [BLOCK_W-1:0] sub_inv(input logic [BLOCK_W-1:0] v);
    logic [BLOCK_W-1:0] r;
    r = '0;
    for (int n = 0; n < BLOCK_W / 4; n++) begin
      r[4*n +: 4] = SBOX_INV[v[4*n +: 4]];
    end
    return r;
  endfunction

  // Bit permutation: output bit p takes input bit (4p mod 63); the top bit stays.
  function automatic logic [BLOCK_W-1:0] perm_fwd(input logic [BLOCK_W-1:0] v);
    logic [BLOCK_W-1:0] r;
    r = '0;
    r[BLOCK_W-1] = v[BLOCK_W-1];
    for (int p = 0; p < BLOCK_W - 1; p++) begin
      r[p] = v[(p * 4) % (BLOCK_W - 1)];
    end
    return r;
  endfunction

  // Inverse permutation: output bit q takes input bit (16q mod 63).
  function automatic logic [BLOCK_W-1:0] perm_inv(input logic [BLOCK_W-1:0] v);
    logic [BLOCK_W-1:0] r;
    r = '0;
    r[BLOCK_W-1] = v[BLOCK_W-1];
    for (int q = 0; q < BLOCK_W - 1; q++) begin
      r[q] = v[(q * 16) % (BLOCK_W - 1)];
    end
    return r;
  endfunction

  // One cipher round in either direction with its round key.
  function automatic logic [BLOCK_W-1:0] round_fn(input logic op,
                                                  input logic [BLOCK_W-1:0] b,
                                                  input logic [KEY_W-1:0] k);
    logic [BLOCK_W-1:0] x;
    x = b ^ k;
    if (op == OP_DECRYPT) begin
      return sub_inv(perm_inv(x));
    end
    return perm_fwd(sub_fwd(x));
  endfunction

  // One step of the 128-bit key schedule; returns the new {high, low} pair.
  function automatic logic [2*KEY_W-1:0] key_update(input logic [KEY_W-1:0] hi,
                                                    input logic [KEY_W-1:0] lo,
                                                    input logic [RC_W-1:0] rc);
    logic [KEY_W-1:0] nh;
    logic [KEY_W-1:0] nl;
    nh = {hi[2:0], lo[KEY_W-1:3]};
    nl = {lo[2:0], hi[KEY_W-1:3]};
    nh[KEY_W-1 -: 4] = SBOX[nh[KEY_W-1 -: 4]];
    nh[KEY_W-5 -: 4] = SBOX[nh[KEY_W-5 -: 4]];
    nh[2:0] = nh[2:0] ^ rc[RC_W-1:2];
    nl[KEY_W-1 -: 2] = nl[KEY_W-1 -: 2] ^ rc[1:0];
    return {nh, nl};
  endfunction

endpackage

### design/present128_block_cipher.sv
// Channel   Signals                                   Direction  Transaction
// input     start, busy, operation, data_in           in/out     start && !busy
// result    done, data_out                            out        done (one cycle)
// config    cfg_valid, cfg_ready, cfg_index, cfg_data in/out     cfg_valid && cfg_ready
//
// One block enters per cycle while busy is low; each of the ROUNDS-1 rounds sits in
// its own register stage and the final key addition adds one more.
// After reset and after every key write, the round-key generator steps one
// schedule round per cycle, restarting on any further write, and holds busy
// high until the last round key has been written.
// Reset is synchronous; results cannot be held off, so the pipeline never stalls.
module present128_block_cipher
  import present_pkg::*;
#(
  parameter int ROUNDS = ROUNDS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic                 operation,
  input  logic [BLOCK_W-1:0]   data_in,
  output logic                 done,
  output logic [BLOCK_W-1:0]   data_out,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [KEY_W-1:0]     cfg_data
);

  localparam int CNT_W  = (ROUNDS > 2) ? $clog2(ROUNDS) : 1;
  localparam int STAGES = ROUNDS - 1;

  logic [KEY_W-1:0] key_high;
  logic [KEY_W-1:0] key_low;

  logic             rekey;
  logic             sweep_active;
  logic [CNT_W-1:0] sweep_cnt;
  logic [KEY_W-1:0] sweep_hi;
  logic [KEY_W-1:0] sweep_lo;
  logic [2*KEY_W-1:0] sweep_next;
  logic [KEY_W-1:0] rk [ROUNDS];

  logic               cfg_write;
  logic               accept;
  logic               st_vld  [STAGES];
  logic               st_op   [STAGES];
  logic [BLOCK_W-1:0] st_data [STAGES];

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign busy      = rekey || sweep_active;
  assign accept    = start && !busy;

  // Key registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_KEY_HIGH: key_high <= cfg_data;
        REG_KEY_LOW:  key_low  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Next schedule state from the running key pair and the round counter.
  assign sweep_next = key_update(sweep_hi, sweep_lo, RC_W'(sweep_cnt));

  // Round-key generator control: restart on reset and on any key write.
  always_ff @(posedge clk) begin
    if (rst) begin
      rekey        <= 1'b1;
      sweep_active <= 1'b0;
      sweep_cnt    <= '0;
    end else if (cfg_write) begin
      rekey        <= 1'b1;
      sweep_active <= 1'b0;
    end else if (rekey) begin
      rekey        <= 1'b0;
      sweep_active <= 1'b1;
      sweep_cnt    <= CNT_W'(1);
    end else if (sweep_active) begin
      sweep_cnt <= sweep_cnt + CNT_W'(1);
      if (sweep_cnt == CNT_W'(ROUNDS - 1)) begin
        sweep_active <= 1'b0;
      end
    end
  end

  // Round-key storage, one entry written per schedule step.
  always_ff @(posedge clk) begin
    if (rekey && !cfg_write) begin
      sweep_hi <= key_high;
      sweep_lo <= key_low;
      rk[0]    <= key_high;
    end else if (sweep_active && !cfg_write) begin
      sweep_hi       <= sweep_next[2*KEY_W-1:KEY_W];
      sweep_lo       <= sweep_next[KEY_W-1:0];
      rk[sweep_cnt]  <= sweep_next[2*KEY_W-1:KEY_W];
    end
  end

  // Round stages; decryption walks the round keys from the top down.
  for (genvar r = 0; r < STAGES; r++) begin : g_round
    logic               in_vld;
    logic               in_op;
    logic [BLOCK_W-1:0] in_data;
    logic [KEY_W-1:0]   rkey;

    if (r == 0) begin : g_first
      assign in_vld  = accept;
      assign in_op   = operation;
      assign in_data = data_in;
    end else begin : g_mid
      assign in_vld  = st_vld[r-1];
      assign in_op   = st_op[r-1];
      assign in_data = st_data[r-1];
    end

    assign rkey = (in_op == OP_DECRYPT) ? rk[ROUNDS-1-r] : rk[r];

    always_ff @(posedge clk) begin
      if (rst) begin
        st_vld[r] <= 1'b0;
      end else begin
        st_vld[r] <= in_vld;
      end
    end

    always_ff @(posedge clk) begin
      st_op[r]   <= in_op;
      st_data[r] <= round_fn(in_op, in_data, rkey);
    end
  end

  // Final key addition into the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= st_vld[STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    data_out <= st_data[STAGES-1] ^
                ((st_op[STAGES-1] == OP_DECRYPT) ? rk[0] : rk[ROUNDS-1]);
  end

`ifndef ASSERT_OFF
  // Every accepted block produces its result strobe.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##ROUNDS done)
    else $error("result strobe missing after accepted block");

  // A key write always blocks input until the round keys are rebuilt.
  a_rekey_busy: assert property (@(posedge clk) disable iff (rst)
    cfg_write |=> busy)
    else $error("input not blocked after key write");

  // Busy drops only once the last round key has been written.
  a_sweep_end: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> ($past(sweep_cnt) == CNT_W'(ROUNDS - 1)))
    else $error("round-key sweep ended early");

  // The schedule never writes over the first round key while running.
  a_sweep_cnt: assert property (@(posedge clk) disable iff (rst)
    sweep_active |-> (sweep_cnt != '0))
    else $error("round-key counter at zero during sweep");
`endif

endmodule

### tb/present128_block_cipher_tb.sv
module present128_block_cipher_tb
  import present_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Register indexes past the end of the list; writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_SETS  = 12;
  localparam int BLOCKS_PER_SET = 150;

  // Tracks the key, predicts each block's cipher output and checks results in order.
  class cipher_scoreboard;
    logic [KEY_W-1:0]   key_hi;
    logic [KEY_W-1:0]   key_lo;
    logic [KEY_W-1:0]   round_key [ROUNDS_DEF];
    logic [3:0]         box_fwd [16];
    logic [3:0]         box_inv [16];
    logic [BLOCK_W-1:0] pending [$];
    int errors;
    int checked;
    int n_encrypt;
    int n_decrypt;
    int key_writes;

    function new();
      box_fwd = '{4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
                  4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2};
      box_inv = '{4'h5, 4'hE, 4'hF, 4'h8, 4'hC, 4'h1, 4'h2, 4'hD,
                  4'hB, 4'h4, 4'h6, 4'h3, 4'h0, 4'h7, 4'h9, 4'hA};
      key_hi = '0;
      key_lo = '0;
      errors = 0;
      checked = 0;
      n_encrypt = 0;
      n_decrypt = 0;
      key_writes = 0;
      build_schedule();
    endfunction

    // Nibble substitution through the forward or inverse table.
    function logic [BLOCK_W-1:0] substitute(logic [BLOCK_W-1:0] v, bit inverse);
      logic [BLOCK_W-1:0] r;
      r = '0;
      for (int n = 0; n < BLOCK_W / 4; n++) begin
        r[4*n +: 4] = inverse ? box_inv[v[4*n +: 4]] : box_fwd[v[4*n +: 4]];
      end
      return r;
    endfunction

    // Output bit p takes input bit (p * stride) mod 63; the top bit is fixed.
    function logic [BLOCK_W-1:0] shuffle_bits(logic [BLOCK_W-1:0] v, int stride);
      logic [BLOCK_W-1:0] r;
      r = '0;
      r[BLOCK_W-1] = v[BLOCK_W-1];
      for (int p = 0; p < BLOCK_W - 1; p++) begin
        r[p] = v[(p * stride) % (BLOCK_W - 1)];
      end
      return r;
    endfunction

    // Expand the 128-bit key into the round keys.
    function void build_schedule();
      logic [KEY_W-1:0] hi;
      logic [KEY_W-1:0] lo;
      logic [KEY_W-1:0] nh;
      logic [KEY_W-1:0] nl;
      logic [4:0]       ctr;
      hi = key_hi;
      lo = key_lo;
      round_key[0] = hi;
      for (int i = 1; i < ROUNDS_DEF; i++) begin
        // Rotate the 128-bit register left by 61.
        nh = {hi[2:0], lo[KEY_W-1:3]};
        nl = {lo[2:0], hi[KEY_W-1:3]};
        nh[63:60] = box_fwd[nh[63:60]];
        nh[59:56] = box_fwd[nh[59:56]];
        // The round counter is kept to five bits and lands on key bits 66..62.
        ctr = i[4:0];
        nh[2:0] = nh[2:0] ^ ctr[4:2];
        nl[63:62] = nl[63:62] ^ ctr[1:0];
        hi = nh;
        lo = nl;
        round_key[i] = hi;
      end
    endfunction

    // A configuration transaction; unknown indexes leave the key alone.
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [KEY_W-1:0] value);
      key_writes++;
      if (idx == REG_KEY_HIGH) begin
        key_hi = value;
      end else if (idx == REG_KEY_LOW) begin
        key_lo = value;
      end
      build_schedule();
    endfunction

    // Full cipher in either direction with the current round keys.
    function logic [BLOCK_W-1:0] cipher(logic op, logic [BLOCK_W-1:0] blk);
      logic [BLOCK_W-1:0] b;
      b = blk;
      if (op == OP_ENCRYPT) begin
        for (int r = 0; r < ROUNDS_DEF - 1; r++) begin
          b = shuffle_bits(substitute(b ^ round_key[r], 1'b0), 4);
        end
        b = b ^ round_key[ROUNDS_DEF-1];
      end else begin
        for (int r = ROUNDS_DEF - 1; r > 0; r--) begin
          b = substitute(shuffle_bits(b ^ round_key[r], 16), 1'b1);
        end
        b = b ^ round_key[0];
      end
      return b;
    endfunction

    // An input transaction was taken: queue its expected output.
    function void note_input(logic op, logic [BLOCK_W-1:0] blk);
      if (op == OP_ENCRYPT) begin
        n_encrypt++;
      end else begin
        n_decrypt++;
      end
      pending.push_back(cipher(op, blk));
    endfunction

    // A result transaction arrived: compare with the oldest expected output.
    function void check_result(logic [BLOCK_W-1:0] got);
      logic [BLOCK_W-1:0] want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got !== want) begin
        $display("%0t: data_out mismatch, expected %h, got %h", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic                 operation;
  logic [BLOCK_W-1:0]   data_in;
  logic                 done;
  logic [BLOCK_W-1:0]   data_out;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [KEY_W-1:0]     cfg_data;

  cipher_scoreboard sb = new();
  int cycles = 0;
  bit gaps_on;

  present128_block_cipher u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .operation (operation),
    .data_in   (data_in),
    .done      (done),
    .data_out  (data_out),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Results cannot be stalled, so every strobe is checked at the edge that ends it.
  always @(posedge clk) begin
    if (!rst && done) begin
      sb.check_result(data_out);
    end
  end

  // Cycle limit for a hung run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycles, sb.pending.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // Present one block and hold it until the block takes it.
  task automatic send_block(input logic op, input logic [BLOCK_W-1:0] blk);
    @(negedge clk);
    start <= 1'b1;
    operation <= op;
    data_in <= blk;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_input(op, blk);
  endtask

  // Leave start low for a number of cycles.
  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // Mostly back-to-back, some short gaps, a few long ones.
  task automatic random_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (!gaps_on || pick < 55) begin
      return;
    end else if (pick < 90) begin
      idle_cycles($urandom_range(1, 3));
    end else begin
      idle_cycles($urandom_range(5, 40));
    end
  endtask

  // Stop sending and wait until every expected result has come back.
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // One register write transaction; valid is lowered by end_config.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [KEY_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.write_reg(idx, value);
  endtask

  task automatic end_config();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random 64-bit word with a bias toward the extremes and single-bit patterns.
  function automatic logic [63:0] random_word();
    logic [63:0] w;
    case ($urandom_range(0, 9))
      0: w = '0;
      1: w = '1;
      2: w = 64'd1 << $urandom_range(0, 63);
      3: w = ~(64'd1 << $urandom_range(0, 63));
      default: w = {$urandom, $urandom};
    endcase
    return w;
  endfunction

  // Directed blocks, each sent in both directions.
  task automatic directed_blocks(input int count);
    logic [BLOCK_W-1:0] patterns [6];
    patterns = '{64'h0, '1, 64'h8000_0000_0000_0000, 64'h1,
                 64'hAAAA_AAAA_AAAA_AAAA, 64'h0123_4567_89AB_CDEF};
    for (int i = 0; i < count; i++) begin
      send_block(OP_ENCRYPT, patterns[i]);
      send_block(OP_DECRYPT, patterns[i]);
    end
  endtask

  initial begin
    int sets;
    rst = 1'b1;
    start = 1'b0;
    operation = OP_ENCRYPT;
    data_in = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_KEY_HIGH;
    cfg_data = '0;
    gaps_on = 1'b0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Directed part: the all-zero key from reset, then the all-ones key.
    sets = 1;
    directed_blocks(6);
    drain();
    write_reg(REG_KEY_HIGH, '1);
    write_reg(REG_KEY_LOW, '1);
    end_config();
    sets++;
    gaps_on = 1'b1;
    directed_blocks(4);
    drain();

    // Random part: each set may change the key setting, with the sender draining in between.
    for (int s = 0; s < RANDOM_SETS; s++) begin
      case (s)
        0: begin
          write_reg(REG_KEY_HIGH, '1);
          write_reg(REG_KEY_LOW, '0);
        end
        1: begin
          // Writes past the register list must leave the key unchanged.
          write_reg(REG_SPARE_A, random_word());
          write_reg(REG_SPARE_B, random_word());
        end
        2: begin
          write_reg(REG_KEY_HIGH, '0);
          write_reg(REG_KEY_LOW, '1);
        end
        default: begin
          if ($urandom_range(0, 2) != 0) begin
            write_reg(REG_KEY_HIGH, random_word());
          end
          if ($urandom_range(0, 2) != 0) begin
            write_reg(REG_KEY_LOW, random_word());
          end
          if ($urandom_range(0, 3) == 0) begin
            write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, random_word());
          end
        end
      endcase
      end_config();
      sets++;
      // Some sets run with no gaps at all.
      gaps_on = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < BLOCKS_PER_SET; i++) begin
        send_block($urandom_range(0, 1) ? OP_DECRYPT : OP_ENCRYPT, random_word());
        random_gap();
      end
      drain();
    end

    // Let any stray result show up before the final check.
    repeat (ROUNDS_DEF + 8) @(posedge clk);
    if (sb.pending.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.pending.size());
      sb.errors++;
    end

    $display("Sent %0d blocks (%0d encrypt, %0d decrypt) under %0d key settings",
             sb.n_encrypt + sb.n_decrypt, sb.n_encrypt, sb.n_decrypt, sets);
    $display("Checked %0d results after %0d register writes, %0d errors",
             sb.checked, sb.key_writes, sb.errors);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
